[src/rcsh_pkg.sv]
// Package for the rectilinear contour scan-line hatch block.
// Holds coordinate types, code constants and the struct types shared by the top level and the sort cell.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rcsh_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MAX_SEGS     = 32;
   localparam int SEG_CW       = $clog2(MAX_SEGS + 1);
   localparam int COORD_W      = 27;
   localparam int DELTA_W      = 21;
   localparam int STEP_W       = 16;
   localparam logic [STEP_W-1:0] STEP_RESET = 16'd500;

   localparam int DVD_W = 2 * COORD_W + 4;
   localparam int DSR_W = COORD_W + 2;

   localparam logic [1:0] KIND_MOVE_X = 2'd0;
   localparam logic [1:0] KIND_MOVE_Y = 2'd1;
   localparam logic [1:0] KIND_NEXT   = 2'd2;
   localparam logic [1:0] KIND_CLEAR  = 2'd3;

   localparam logic [1:0] PH_LOAD = 2'd0;
   localparam logic [1:0] PH_HOR  = 2'd1;
   localparam logic [1:0] PH_VER  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COORD_W:0]   wide_type;

   typedef struct packed {
      logic      valid;
      coord_type value;
   } link_type;

   typedef struct packed {
      logic      full;
      coord_type value;
   } held_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

   function automatic coord_type sat_coord(input wide_type v);
      coord_type r;
      if (v > wide_type'(67108863)) begin
         r = coord_type'(67108863);
      end else if (v < -wide_type'(67108864)) begin
         r = coord_type'(-67108864);
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[src/rcsh_channels.sv]
// Valid/ready channel interfaces for requests and segment results.
// Depends on rcsh_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface rcsh_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           kind;
   logic signed [rcsh_pkg::DELTA_W-1:0]  delta;
   modport source (output valid, kind, delta, input ready);
   modport sink (input valid, kind, delta, output ready);
endinterface

interface rcsh_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 seg_valid;
   logic                                 on_vertical_line;
   logic signed [rcsh_pkg::COORD_W-1:0]  start_x;
   logic signed [rcsh_pkg::COORD_W-1:0]  start_y;
   logic signed [rcsh_pkg::COORD_W-1:0]  end_x;
   logic signed [rcsh_pkg::COORD_W-1:0]  end_y;
   logic [rcsh_pkg::COORD_W-1:0]         seg_length;
   logic                                 last;
   logic                                 scan_done;
   logic                                 overflow;
   modport source (output valid, seg_valid, on_vertical_line, start_x, start_y, end_x,
                   end_y, seg_length, last, scan_done, overflow, input ready);
   modport sink (input valid, seg_valid, on_vertical_line, start_x, start_y, end_x,
                 end_y, seg_length, last, scan_done, overflow, output ready);
endinterface
`default_nettype wire

[src/rectilinear_contour_scanline_hatch.sv]
// Top level of the scan-line hatch: vertex store, edge walk, sort chain and output register.
// Depends on rcsh_pkg, rcsh_channels, rcsh_sort_cell and rcsh_divider.
// A scan line walks the stored vertices through the fetch and edge states, sends a diagonal
// closing edge through the multiply and divide states, then flushes the sort chain and pops
// two crossings per segment into the output register. Reset is synchronous; the line step
// resets to 500 and is set by csr writes, where a step of 0 acts as 1.
`timescale 1ns / 1ps
`default_nettype none
module rectilinear_contour_scanline_hatch #(
   parameter int MAX_VERTICES = rcsh_pkg::MAX_VERTICES
) (
   input  logic                          clock,
   input  logic                          reset,
   rcsh_req_if.sink                      req_ch,
   rcsh_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [rcsh_pkg::STEP_W-1:0]   csr_wr_data
);

   localparam int AW     = $clog2(MAX_VERTICES);
   localparam int CW     = $clog2(MAX_VERTICES + 1);
   localparam int SEG_CW = rcsh_pkg::SEG_CW;
   localparam int PW     = (CW > SEG_CW) ? CW : SEG_CW;
   localparam int CWD    = rcsh_pkg::COORD_W;
   localparam int DSR_W  = rcsh_pkg::DSR_W;
   localparam int DVD_W  = rcsh_pkg::DVD_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_FETCH = 4'd2;
   localparam logic [3:0] S_EDGE  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_DSET  = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_FLUSH = 4'd7;
   localparam logic [3:0] S_POPA  = 4'd8;
   localparam logic [3:0] S_POPB  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   typedef rcsh_pkg::coord_type coord_type;
   typedef rcsh_pkg::wide_type  wide_type;

   logic [2*CWD-1:0] vmem [MAX_VERTICES];

   logic [rcsh_pkg::STEP_W-1:0] step_ff;
   logic [3:0]   state_ff, state_in;
   logic [1:0]   phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   coord_type    curx_ff, curx_in, cury_ff, cury_in;
   coord_type    minx_ff, minx_in, maxx_ff, maxx_in;
   coord_type    miny_ff, miny_in, maxy_ff, maxy_in;
   coord_type    line_ff, line_in;
   logic         ovf_ff, ovf_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] ncross_ff, ncross_in;
   logic [CW-1:0] flush_ff, flush_in;
   logic         vert_ff, vert_in, done_ff, done_in, special_ff, special_in;
   logic [SEG_CW-1:0] seg_idx_ff, seg_idx_in;

   coord_type    px_ff, px_in, py_ff, py_in;
   logic [2*CWD-1:0] rd_data_ff;
   logic         rd_zero_ff;
   coord_type    seg_a_ff, seg_a_in, seg_b_ff, seg_b_in;
   wide_type     dl_ff, dl_in, dw_ff, dw_in, du_ff, du_in;
   coord_type    w1_ff, w1_in;
   logic signed [2*CWD+1:0] prod_ff;
   logic         neg_ff, neg_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic         o_seg_valid_ff, o_vert_ff, o_last_ff, o_done_ff, o_ovf_ff;
   coord_type    o_sx_ff, o_sy_ff, o_ex_ff, o_ey_ff;
   logic [CWD-1:0] o_len_ff;
   logic         o_load;
   coord_type    o_sx, o_sy, o_ex, o_ey;
   logic [CWD-1:0] o_len;
   logic         o_last;

   logic         accept, mem_we;
   coord_type    new_x, new_y;
   logic [rcsh_pkg::STEP_W-1:0] step_eff;
   wide_type     line_plus;
   logic [AW-1:0] fetch_addr;
   coord_type    cur_x, cur_y, u1, u2, w1, w2;
   logic         skip_edge, advance, last_edge;
   logic [PW-1:0] pairs_w;
   logic [SEG_CW-1:0] pairs;
   logic         seg_last;

   logic         div_start, div_done;
   logic [DSR_W-1:0] div_q;
   logic [2*CWD+1:0] abs_prod;
   logic [CWD:0] abs_du;
   logic [DVD_W-1:0] div_dividend;
   logic [DSR_W-1:0] div_divisor;
   logic signed [DSR_W:0] q_signed;
   logic signed [DSR_W:0] cross_sum;

   rcsh_pkg::link_type      ins_link;
   rcsh_pkg::cell_ctrl_type cell_ctrl;
   rcsh_pkg::link_type      links [MAX_VERTICES+1];
   rcsh_pkg::held_type      helds [MAX_VERTICES+1];

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign step_eff     = (step_ff == '0) ? rcsh_pkg::STEP_W'(1) : step_ff;
   assign line_plus    = wide_type'(line_ff) + wide_type'({1'b0, step_eff});
   assign fetch_addr   = (ptr_ff == count_ff) ? '0 : ptr_ff[AW-1:0];
   assign cur_x        = rd_zero_ff ? '0 : rd_data_ff[2*CWD-1:CWD];
   assign cur_y        = rd_zero_ff ? '0 : rd_data_ff[CWD-1:0];
   assign u1 = vert_ff ? px_ff : py_ff;
   assign u2 = vert_ff ? cur_x : cur_y;
   assign w1 = vert_ff ? py_ff : px_ff;
   assign w2 = vert_ff ? cur_y : cur_x;
   assign skip_edge = (u1 == u2) || ((u1 > line_ff) && (u2 > line_ff))
                      || ((u1 < line_ff) && (u2 < line_ff));
   assign last_edge = (ptr_ff == count_ff);
   assign pairs_w   = PW'(ncross_ff >> 1);
   assign pairs     = (pairs_w > PW'(rcsh_pkg::MAX_SEGS)) ? SEG_CW'(rcsh_pkg::MAX_SEGS)
                                                          : SEG_CW'(pairs_w);
   assign seg_last  = ((seg_idx_ff + SEG_CW'(1)) == pairs);

   assign abs_prod     = prod_ff[2*CWD+1] ? (2*CWD+2)'(-prod_ff) : prod_ff;
   assign abs_du       = du_ff[CWD] ? (CWD+1)'(-du_ff) : du_ff;
   assign div_dividend = DVD_W'({abs_prod, 1'b0}) + DVD_W'(abs_du);
   assign div_divisor  = {abs_du, 1'b0};
   assign div_start    = (state_ff == S_DSET);
   assign q_signed     = neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
   assign cross_sum    = (DSR_W+1)'(w1_ff) + q_signed;

   always_comb begin
      new_x = curx_ff;
      new_y = cury_ff;
      if (req_ch.kind == rcsh_pkg::KIND_MOVE_X) begin
         new_x = rcsh_pkg::sat_coord(wide_type'(curx_ff) + wide_type'(req_ch.delta));
      end else begin
         new_y = rcsh_pkg::sat_coord(wide_type'(cury_ff) + wide_type'(req_ch.delta));
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      curx_in    = curx_ff;
      cury_in    = cury_ff;
      minx_in    = minx_ff;
      maxx_in    = maxx_ff;
      miny_in    = miny_ff;
      maxy_in    = maxy_ff;
      line_in    = line_ff;
      ovf_in     = ovf_ff;
      ptr_in     = ptr_ff;
      ncross_in  = ncross_ff;
      flush_in   = flush_ff;
      vert_in    = vert_ff;
      done_in    = done_ff;
      special_in = special_ff;
      seg_idx_in = seg_idx_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      seg_a_in   = seg_a_ff;
      seg_b_in   = seg_b_ff;
      dl_in      = dl_ff;
      dw_in      = dw_ff;
      du_in      = du_ff;
      w1_in      = w1_ff;
      neg_in     = neg_ff;
      mem_we     = 1'b0;
      advance    = 1'b0;
      ins_link.valid  = 1'b0;
      ins_link.value  = w1;
      cell_ctrl.clear = 1'b0;
      cell_ctrl.shift = 1'b0;
      o_load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_ch.kind)
                  rcsh_pkg::KIND_MOVE_X, rcsh_pkg::KIND_MOVE_Y: begin
                     if (phase_ff == rcsh_pkg::PH_LOAD) begin
                        if (count_ff >= CW'(MAX_VERTICES)) begin
                           ovf_in = 1'b1;
                        end else begin
                           mem_we   = 1'b1;
                           count_in = count_ff + CW'(1);
                           curx_in  = new_x;
                           cury_in  = new_y;
                           if (new_x < minx_ff) minx_in = new_x;
                           if (new_x > maxx_ff) maxx_in = new_x;
                           if (new_y < miny_ff) miny_in = new_y;
                           if (new_y > maxy_ff) maxy_in = new_y;
                        end
                     end
                  end
                  rcsh_pkg::KIND_CLEAR: begin
                     count_in = CW'(1);
                     curx_in  = '0;
                     cury_in  = '0;
                     minx_in  = '0;
                     maxx_in  = '0;
                     miny_in  = '0;
                     maxy_in  = '0;
                     line_in  = '0;
                     phase_in = rcsh_pkg::PH_LOAD;
                     ovf_in   = 1'b0;
                  end
                  default: begin
                     state_in = S_START;
                     case (phase_ff)
                        rcsh_pkg::PH_LOAD: begin
                           phase_in = rcsh_pkg::PH_HOR;
                           line_in  = miny_ff;
                        end
                        rcsh_pkg::PH_HOR: begin
                           if (line_plus > wide_type'(maxy_ff)) begin
                              phase_in = rcsh_pkg::PH_VER;
                              line_in  = minx_ff;
                           end else begin
                              line_in = line_plus[CWD-1:0];
                           end
                        end
                        rcsh_pkg::PH_VER: begin
                           if (line_plus > wide_type'(maxx_ff)) begin
                              phase_in   = rcsh_pkg::PH_DONE;
                              vert_in    = 1'b0;
                              done_in    = 1'b1;
                              special_in = 1'b1;
                              state_in   = S_OUT;
                           end else begin
                              line_in = line_plus[CWD-1:0];
                           end
                        end
                        default: begin
                           vert_in    = 1'b0;
                           done_in    = 1'b1;
                           special_in = 1'b1;
                           state_in   = S_OUT;
                        end
                     endcase
                  end
               endcase
            end
         end
         S_START: begin
            vert_in    = (phase_ff == rcsh_pkg::PH_VER);
            done_in    = (phase_ff == rcsh_pkg::PH_VER) && (line_plus > wide_type'(maxx_ff));
            special_in = 1'b0;
            ptr_in     = '0;
            ncross_in  = '0;
            cell_ctrl.clear = 1'b1;
            state_in   = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_EDGE;
         end
         S_EDGE: begin
            if (ptr_ff == '0 || skip_edge) begin
               advance = 1'b1;
            end else if (w1 == w2) begin
               ins_link.valid = 1'b1;
               ncross_in      = ncross_ff + CW'(1);
               advance        = 1'b1;
            end else begin
               dl_in    = wide_type'(line_ff) - wide_type'(u1);
               dw_in    = wide_type'(w2) - wide_type'(w1);
               du_in    = wide_type'(u2) - wide_type'(u1);
               w1_in    = w1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_DSET;
         end
         S_DSET: begin
            neg_in   = prod_ff[2*CWD+1] ^ du_ff[CWD];
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               ins_link.valid = 1'b1;
               ins_link.value = cross_sum[CWD-1:0];
               ncross_in      = ncross_ff + CW'(1);
               advance        = 1'b1;
            end
         end
         S_FLUSH: begin
            flush_in = flush_ff + CW'(1);
            if (flush_ff == CW'(MAX_VERTICES)) begin
               seg_idx_in = '0;
               if (pairs == '0) begin
                  special_in = 1'b1;
                  state_in   = S_OUT;
               end else begin
                  state_in = S_POPA;
               end
            end
         end
         S_POPA: begin
            seg_a_in        = helds[0].value;
            cell_ctrl.shift = 1'b1;
            state_in        = S_POPB;
         end
         S_POPB: begin
            seg_b_in        = helds[0].value;
            cell_ctrl.shift = 1'b1;
            state_in        = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               o_load = 1'b1;
               if (special_ff || seg_last) begin
                  state_in = S_IDLE;
               end else begin
                  seg_idx_in = seg_idx_ff + SEG_CW'(1);
                  state_in   = S_POPA;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (advance) begin
         px_in = cur_x;
         py_in = cur_y;
         if (last_edge) begin
            flush_in = '0;
            state_in = S_FLUSH;
         end else begin
            ptr_in   = ptr_ff + CW'(1);
            state_in = S_FETCH;
         end
      end
   end

   always_comb begin
      o_sx   = '0;
      o_sy   = '0;
      o_ex   = '0;
      o_ey   = '0;
      o_len  = '0;
      o_last = special_ff || seg_last;
      if (!special_ff) begin
         o_len = seg_b_ff - seg_a_ff;
         if (vert_ff) begin
            o_sx = line_ff;
            o_sy = seg_a_ff;
            o_ex = line_ff;
            o_ey = seg_b_ff;
         end else begin
            o_sx = seg_a_ff;
            o_sy = line_ff;
            o_ex = seg_b_ff;
            o_ey = line_ff;
         end
      end
      rsp_valid_in = o_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= rcsh_pkg::STEP_RESET;
         state_ff     <= S_IDLE;
         phase_ff     <= rcsh_pkg::PH_LOAD;
         count_ff     <= CW'(1);
         curx_ff      <= '0;
         cury_ff      <= '0;
         minx_ff      <= '0;
         maxx_ff      <= '0;
         miny_ff      <= '0;
         maxy_ff      <= '0;
         line_ff      <= '0;
         ovf_ff       <= 1'b0;
         ptr_ff       <= '0;
         ncross_ff    <= '0;
         flush_ff     <= '0;
         vert_ff      <= 1'b0;
         done_ff      <= 1'b0;
         special_ff   <= 1'b0;
         seg_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) step_ff <= csr_wr_data;
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         curx_ff      <= curx_in;
         cury_ff      <= cury_in;
         minx_ff      <= minx_in;
         maxx_ff      <= maxx_in;
         miny_ff      <= miny_in;
         maxy_ff      <= maxy_in;
         line_ff      <= line_in;
         ovf_ff       <= ovf_in;
         ptr_ff       <= ptr_in;
         ncross_ff    <= ncross_in;
         flush_ff     <= flush_in;
         vert_ff      <= vert_in;
         done_ff      <= done_in;
         special_ff   <= special_in;
         seg_idx_ff   <= seg_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) vmem[count_ff[AW-1:0]] <= {new_x, new_y};
      if (state_ff == S_FETCH) begin
         rd_data_ff <= vmem[fetch_addr];
         rd_zero_ff <= (fetch_addr == '0);
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      seg_a_ff <= seg_a_in;
      seg_b_ff <= seg_b_in;
      dl_ff    <= dl_in;
      dw_ff    <= dw_in;
      du_ff    <= du_in;
      w1_ff    <= w1_in;
      neg_ff   <= neg_in;
      prod_ff  <= dl_ff * dw_ff;
      if (o_load) begin
         o_seg_valid_ff <= !special_ff;
         o_vert_ff      <= vert_ff;
         o_sx_ff        <= o_sx;
         o_sy_ff        <= o_sy;
         o_ex_ff        <= o_ex;
         o_ey_ff        <= o_ey;
         o_len_ff       <= o_len;
         o_last_ff      <= o_last;
         o_done_ff      <= done_ff;
         o_ovf_ff       <= ovf_ff;
      end
   end

   rcsh_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign links[0]           = ins_link;
   assign helds[MAX_VERTICES] = '0;

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      rcsh_sort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .in_link    (links[i]),
         .right_held (helds[i+1]),
         .out_link   (links[i+1]),
         .held       (helds[i])
      );
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.seg_valid        = o_seg_valid_ff;
   assign rsp_ch.on_vertical_line = o_vert_ff;
   assign rsp_ch.start_x          = o_sx_ff;
   assign rsp_ch.start_y          = o_sy_ff;
   assign rsp_ch.end_x            = o_ex_ff;
   assign rsp_ch.end_y            = o_ey_ff;
   assign rsp_ch.seg_length       = o_len_ff;
   assign rsp_ch.last             = o_last_ff;
   assign rsp_ch.scan_done        = o_done_ff;
   assign rsp_ch.overflow         = o_ovf_ff;

endmodule
`default_nettype wire

[src/rcsh_sort_cell.sv]
// One cell of the insertion-sort chain that orders the crossings of a scan line.
// Depends on rcsh_pkg for the link, held and control struct types.
`timescale 1ns / 1ps
`default_nettype none
module rcsh_sort_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  rcsh_pkg::cell_ctrl_type ctrl,
   input  rcsh_pkg::link_type      in_link,
   input  rcsh_pkg::held_type      right_held,
   output rcsh_pkg::link_type      out_link,
   output rcsh_pkg::held_type      held
);

   logic                full_ff, full_in;
   rcsh_pkg::coord_type value_ff, value_in;
   logic                pass_valid_ff, pass_valid_in;
   rcsh_pkg::coord_type pass_value_ff, pass_value_in;

   always_comb begin
      full_in       = full_ff;
      value_in      = value_ff;
      pass_valid_in = 1'b0;
      pass_value_in = pass_value_ff;
      if (ctrl.clear) begin
         full_in = 1'b0;
      end else if (ctrl.shift) begin
         full_in  = right_held.full;
         value_in = right_held.value;
      end else if (in_link.valid) begin
         if (!full_ff) begin
            full_in  = 1'b1;
            value_in = in_link.value;
         end else if (in_link.value < value_ff) begin
            value_in      = in_link.value;
            pass_valid_in = 1'b1;
            pass_value_in = value_ff;
         end else begin
            pass_valid_in = 1'b1;
            pass_value_in = in_link.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff       <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         full_ff       <= full_in;
         pass_valid_ff <= pass_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      pass_value_ff <= pass_value_in;
   end

   assign out_link.valid = pass_valid_ff;
   assign out_link.value = pass_value_ff;
   assign held.full      = full_ff;
   assign held.value     = value_ff;

endmodule
`default_nettype wire

[src/rcsh_divider.sv]
// Restoring divider, one quotient bit per cycle, for the diagonal closing edge.
// Depends on rcsh_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps
`default_nettype none
module rcsh_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rcsh_pkg::DVD_W-1:0]  dividend,
   input  logic [rcsh_pkg::DSR_W-1:0]  divisor,
   output logic                        done,
   output logic [rcsh_pkg::DSR_W-1:0]  quotient
);

   localparam int DVD_W = rcsh_pkg::DVD_W;
   localparam int DSR_W = rcsh_pkg::DSR_W;
   localparam int NW    = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W-1:0] quo_ff, quo_in;
   logic [DSR_W:0]   shifted;
   logic [DSR_W+1:0] trial;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      fits    = !trial[DSR_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = NW'(DVD_W);
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DSR_W-2:0], fits};
         cnt_in = cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[src/rcsh_checker.sv]
// Port-level assertions for the scan-line hatch top level, attached by bind.
// Depends on rcsh_pkg and rcsh_channels.
`timescale 1ns / 1ps
`default_nettype none
module rcsh_checker (
   input logic        clock,
   input logic        reset,
   rcsh_req_if.sink   req_ch,
   rcsh_rsp_if.source rsp_ch
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("A stalled result was withdrawn.");

   a_busy_after_line: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && (req_ch.kind == rcsh_pkg::KIND_NEXT) |=> !req_ch.ready)
      else $error("A next-line request did not make the block busy.");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.seg_valid |-> rsp_ch.last)
      else $error("An empty-line result was not marked last.");

   a_horizontal_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.seg_valid && !rsp_ch.on_vertical_line
      |-> (rsp_ch.start_y == rsp_ch.end_y))
      else $error("A horizontal segment has different end-point y values.");

endmodule

bind rectilinear_contour_scanline_hatch rcsh_checker u_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
`default_nettype wire

[test/tb.sv]
// Testbench for the rectilinear contour scan-line hatch block.
// Drives contours, scan-line requests and line step writes, and checks each segment
// against an in-bench predictor. Depends on rcsh_pkg, rcsh_channels and the top level.
`timescale 1ns / 1ps
module tb;

   localparam int COORD_W = rcsh_pkg::COORD_W;
   localparam int DELTA_W = rcsh_pkg::DELTA_W;
   localparam int STEP_W = rcsh_pkg::STEP_W;
   localparam int LIMIT_CYCLES = 3000000;
   localparam int SETTLE_CYCLES = 600;

   typedef struct packed {
      logic                      seg_valid;
      logic                      on_vertical_line;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [COORD_W-1:0]        seg_length;
      logic                      last;
      logic                      scan_done;
      logic                      overflow;
   } segment_type;

   class hatch_scoreboard;
      longint      vx[rcsh_pkg::MAX_VERTICES];
      longint      vy[rcsh_pkg::MAX_VERTICES];
      int          vcount;
      longint      cur_x, cur_y, min_x, max_x, min_y, max_y, line_pos;
      logic [1:0]  phase;
      bit          ovf;
      int unsigned step_reg;
      longint      crossings[rcsh_pkg::MAX_VERTICES];
      segment_type expected_segments[$];
      int          errors;

      function new();
         clear_contour();
         step_reg = rcsh_pkg::STEP_RESET;
         errors = 0;
      endfunction

      function void clear_contour();
         vx[0] = 0;
         vy[0] = 0;
         vcount = 1;
         cur_x = 0;
         cur_y = 0;
         min_x = 0;
         max_x = 0;
         min_y = 0;
         max_y = 0;
         line_pos = 0;
         phase = rcsh_pkg::PH_LOAD;
         ovf = 0;
      endfunction

      function longint clamp(longint v);
         if (v > 67108863) return 67108863;
         if (v < -67108864) return -67108864;
         return v;
      endfunction

      function longint round_div(longint num, longint den);
         bit     neg;
         longint an, ad, q;
         neg = (num < 0) != (den < 0);
         an = (num < 0) ? -num : num;
         ad = (den < 0) ? -den : den;
         q = (2 * an + ad) / (2 * ad);
         return neg ? -q : q;
      endfunction

      function void push(bit valid, bit vert, longint sx, longint sy, longint ex, longint ey,
                         longint len, bit lst, bit done);
         segment_type s;
         s.seg_valid = valid;
         s.on_vertical_line = vert;
         s.start_x = COORD_W'(sx);
         s.start_y = COORD_W'(sy);
         s.end_x = COORD_W'(ex);
         s.end_y = COORD_W'(ey);
         s.seg_length = COORD_W'(len);
         s.last = lst;
         s.scan_done = done;
         s.overflow = ovf;
         expected_segments.insert(expected_segments.size(), s);
      endfunction

      function void hatch_line(bit vert, bit done);
         int     n, k, pairs, j;
         longint u1, u2, w1, w2, c, a, b;
         n = 0;
         for (int i = 0; i < vcount; i++) begin
            j = (i + 1 == vcount) ? 0 : i + 1;
            u1 = vert ? vx[i] : vy[i];
            u2 = vert ? vx[j] : vy[j];
            w1 = vert ? vy[i] : vx[i];
            w2 = vert ? vy[j] : vx[j];
            if (u1 == u2) continue;
            if ((u1 > line_pos && u2 > line_pos) || (u1 < line_pos && u2 < line_pos)) continue;
            c = (w1 == w2) ? w1 : w1 + round_div((line_pos - u1) * (w2 - w1), u2 - u1);
            k = n;
            while (k > 0 && crossings[k-1] > c) begin
               crossings[k] = crossings[k-1];
               k--;
            end
            crossings[k] = c;
            n++;
         end
         pairs = n / 2;
         if (pairs > rcsh_pkg::MAX_SEGS) pairs = rcsh_pkg::MAX_SEGS;
         if (pairs == 0) begin
            push(0, vert, 0, 0, 0, 0, 0, 1, done);
            return;
         end
         for (k = 0; k < pairs; k++) begin
            a = crossings[2*k];
            b = crossings[2*k+1];
            if (vert) push(1, 1, line_pos, a, line_pos, b, b - a, k + 1 == pairs, done);
            else push(1, 0, a, line_pos, b, line_pos, b - a, k + 1 == pairs, done);
         end
      endfunction

      function void note(logic [1:0] kind, logic signed [DELTA_W-1:0] delta);
         longint dl, st, nx, ny;
         dl = delta;
         st = (step_reg == 0) ? 1 : step_reg;
         if (kind == rcsh_pkg::KIND_MOVE_X || kind == rcsh_pkg::KIND_MOVE_Y) begin
            if (phase != rcsh_pkg::PH_LOAD) return;
            if (vcount >= rcsh_pkg::MAX_VERTICES) begin
               ovf = 1;
               return;
            end
            nx = cur_x;
            ny = cur_y;
            if (kind == rcsh_pkg::KIND_MOVE_X) nx = clamp(cur_x + dl);
            else ny = clamp(cur_y + dl);
            cur_x = nx;
            cur_y = ny;
            vx[vcount] = nx;
            vy[vcount] = ny;
            vcount++;
            if (nx < min_x) min_x = nx;
            if (nx > max_x) max_x = nx;
            if (ny < min_y) min_y = ny;
            if (ny > max_y) max_y = ny;
            return;
         end
         if (kind == rcsh_pkg::KIND_CLEAR) begin
            clear_contour();
            return;
         end
         if (phase == rcsh_pkg::PH_LOAD) begin
            phase = rcsh_pkg::PH_HOR;
            line_pos = min_y;
         end else if (phase == rcsh_pkg::PH_HOR) begin
            line_pos += st;
            if (line_pos > max_y) begin
               phase = rcsh_pkg::PH_VER;
               line_pos = min_x;
            end
         end else if (phase == rcsh_pkg::PH_VER) begin
            if (line_pos + st > max_x) phase = rcsh_pkg::PH_DONE;
            else line_pos += st;
         end
         if (phase == rcsh_pkg::PH_DONE) begin
            push(0, 0, 0, 0, 0, 0, 0, 1, 1);
            return;
         end
         hatch_line(phase == rcsh_pkg::PH_VER,
                    phase == rcsh_pkg::PH_VER && line_pos + st > max_x);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check(segment_type got);
         segment_type e;
         if (expected_segments.size() == 0) begin
            report("unexpected segment", 1, 0);
            return;
         end
         e = expected_segments.pop_front();
         if (got.seg_valid !== e.seg_valid) report("seg_valid", got.seg_valid, e.seg_valid);
         if (got.on_vertical_line !== e.on_vertical_line)
            report("on_vertical_line", got.on_vertical_line, e.on_vertical_line);
         if (got.start_x !== e.start_x) report("start_x", got.start_x, e.start_x);
         if (got.start_y !== e.start_y) report("start_y", got.start_y, e.start_y);
         if (got.end_x !== e.end_x) report("end_x", got.end_x, e.end_x);
         if (got.end_y !== e.end_y) report("end_y", got.end_y, e.end_y);
         if (got.seg_length !== e.seg_length) report("seg_length", got.seg_length, e.seg_length);
         if (got.last !== e.last) report("last", got.last, e.last);
         if (got.scan_done !== e.scan_done) report("scan_done", got.scan_done, e.scan_done);
         if (got.overflow !== e.overflow) report("overflow", got.overflow, e.overflow);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [STEP_W-1:0] csr_wr_data = '0;
   int cycles = 0;
   int items = 0;
   int burst_left = 0;
   int rx_mode = 0, rx_period = 4, rx_duty = 2, rx_count = 0, rx_left = 100;
   hatch_scoreboard sb = new();

   rcsh_req_if req_if();
   rcsh_rsp_if rsp_if();

   initial begin
      req_if.valid = 0;
      req_if.kind = rcsh_pkg::KIND_MOVE_X;
      req_if.delta = '0;
      rsp_if.ready = 0;
   end

   rectilinear_contour_scanline_hatch u_top (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      segment_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.seg_valid = rsp_if.seg_valid;
         got.on_vertical_line = rsp_if.on_vertical_line;
         got.start_x = rsp_if.start_x;
         got.start_y = rsp_if.start_y;
         got.end_x = rsp_if.end_x;
         got.end_y = rsp_if.end_y;
         got.seg_length = rsp_if.seg_length;
         got.last = rsp_if.last;
         got.scan_done = rsp_if.scan_done;
         got.overflow = rsp_if.overflow;
         sb.check(got);
      end
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 2);
         rx_period = $urandom_range(2, 16);
         rx_duty = $urandom_range(1, rx_period - 1);
         rx_left = $urandom_range(200, 2000);
      end
      rx_left--;
      rx_count++;
      case (rx_mode)
         0: rsp_if.ready <= 1;
         1: rsp_if.ready <= (rx_count % rx_period) < rx_duty;
         default: rsp_if.ready <= 1'($urandom_range(0, 1));
      endcase
   end

   task automatic send(logic [1:0] kind, logic signed [DELTA_W-1:0] delta);
      req_if.valid <= 1;
      req_if.kind <= kind;
      req_if.delta <= delta;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note(kind, delta);
      items++;
      if (burst_left == 0) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 0;
      while (sb.expected_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_step(logic [STEP_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en <= 1;
      @(posedge clock);
      sb.step_reg = 32'(value);
      csr_wr_en <= 0;
   endtask

   task automatic scan_to_end();
      while (sb.phase != rcsh_pkg::PH_DONE) begin
         send(rcsh_pkg::KIND_NEXT, DELTA_W'($urandom));
         if ($urandom_range(0, 9) == 0) send(2'($urandom_range(0, 1)), DELTA_W'($urandom));
      end
      repeat ($urandom_range(0, 2)) send(rcsh_pkg::KIND_NEXT, DELTA_W'($urandom));
   endtask

   task automatic run_contour(int nmoves, int mag, bit full_range, bit full_scan);
      bit axis;
      logic signed [DELTA_W-1:0] d;
      send(rcsh_pkg::KIND_CLEAR, DELTA_W'($urandom));
      axis = 1'($urandom_range(0, 1));
      for (int i = 0; i < nmoves; i++) begin
         if ($urandom_range(0, 4) != 0) axis = !axis;
         if (full_range) d = DELTA_W'($urandom);
         else d = DELTA_W'($signed($urandom_range(0, 2 * mag)) - mag);
         send(axis ? rcsh_pkg::KIND_MOVE_Y : rcsh_pkg::KIND_MOVE_X, d);
      end
      if (full_scan) scan_to_end();
      else repeat ($urandom_range(0, 5)) send(rcsh_pkg::KIND_NEXT, DELTA_W'($urandom));
   endtask

   initial begin
      int st, eff;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(rcsh_pkg::KIND_MOVE_X, 21'sd1000);
      send(rcsh_pkg::KIND_MOVE_Y, 21'sd1000);
      send(rcsh_pkg::KIND_MOVE_X, -21'sd1000);
      send(rcsh_pkg::KIND_MOVE_Y, -21'sd1000);
      send(rcsh_pkg::KIND_NEXT, 21'sd0);
      send(rcsh_pkg::KIND_MOVE_X, 21'sh0FFFFF);
      scan_to_end();
      send(rcsh_pkg::KIND_CLEAR, 21'sd0);
      wait_idle();
      set_step(16'd0);
      send(rcsh_pkg::KIND_MOVE_X, 21'sd3);
      send(rcsh_pkg::KIND_MOVE_Y, 21'sd2);
      scan_to_end();
      wait_idle();
      set_step(16'hFFFF);
      send(rcsh_pkg::KIND_CLEAR, 21'sd0);
      send(rcsh_pkg::KIND_MOVE_X, 21'sh100000);
      send(rcsh_pkg::KIND_MOVE_Y, 21'sd1048575);
      repeat (3) send(rcsh_pkg::KIND_NEXT, 21'sd0);

      while (items < 420) begin
         case ($urandom_range(0, 5))
            0: st = 1;
            1: st = 16'hFFFF;
            2: st = 500;
            3: st = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 64);
            default: st = $urandom_range(1, 16'hFFFF);
         endcase
         wait_idle();
         set_step(STEP_W'(st));
         eff = (st == 0) ? 1 : st;
         repeat (3) begin
            case ($urandom_range(0, 7))
               0: run_contour($urandom_range(60, 70), eff, 1'($urandom_range(0, 1)), 0);
               1: run_contour($urandom_range(60, 70), eff, 0, 1);
               2: run_contour($urandom_range(1, 10), 2 * eff, 0, 0);
               default: run_contour($urandom_range(1, 8), eff * $urandom_range(1, 2), 0, 1);
            endcase
         end
      end

      wait_idle();
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

[rectilinear_contour_scanline_hatch.f]
src/rcsh_pkg.sv
src/rcsh_channels.sv
src/rcsh_sort_cell.sv
src/rcsh_divider.sv
src/rectilinear_contour_scanline_hatch.sv
src/rcsh_checker.sv
test/tb.sv
